### hdl/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers used by the clns_checker module.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Immediate-cycle implication, sampled on clk, quiet while rst_n is low
`define ASSERT_IMP(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, quiet while rst_n is low
`define ASSERT_NXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error(msg);

`endif

### hdl/clns_pkg.sv
// ---------------------------------------------------------------------------
// clns_pkg
// Types, constants and start-up tables for the character LCD nibble
// write sequencer.
// ---------------------------------------------------------------------------
package clns_pkg;

  // Timing defaults, in microseconds
  localparam int PULSE_US_DEF    = 10;
  localparam int BYTE_GAP_US_DEF = 100;

  // Segment counter
  localparam int          CNT_W     = 24;
  localparam logic [23:0] COUNT_MAX = 24'hFF_FFFF;

  // Timer rate register
  localparam int         TPU_W     = 8;
  localparam logic [7:0] TPU_RESET = 8'd3;

  // Start-up list
  localparam int          IDX_W         = 4;
  localparam logic [3:0]  INIT_LEN      = 4'd9;
  localparam int          INIT_WAIT_W   = 14;
  localparam int          INIT_WAIT_MAX = 10000;

  // Configuration port
  localparam int         CFG_AW  = 3;
  localparam int         CFG_DW  = 32;
  localparam logic [0:0] REG_TPU = 1'b0;

  // Item operation codes
  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_WRITE = 2'd1,
    OP_INIT  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  // Sequencer phase: E low / high / low per nibble, then the gap
  typedef enum logic [2:0] {
    PH_IDLE     = 3'd0,
    PH_HI_SETUP = 3'd1,
    PH_HI_PULSE = 3'd2,
    PH_HI_HOLD  = 3'd3,
    PH_LO_SETUP = 3'd4,
    PH_LO_PULSE = 3'd5,
    PH_LO_HOLD  = 3'd6,
    PH_GAP      = 3'd7
  } phase_t;

  // Input beat
  typedef struct packed {
    logic [1:0] op;
    logic       reg_select;
    logic [7:0] byte_value;
  } in_beat_t;

  // Result beat
  typedef struct packed {
    logic       enable_pin;
    logic       rs_pin;
    logic [3:0] data_pins;
    logic       busy_res;
    logic       rejected;
  } out_beat_t;

  // Start-up command bytes
  function automatic logic [7:0] init_byte(input logic [3:0] idx);
    logic [7:0] b;
    unique case (idx)
      4'd0, 4'd1, 4'd2: b = 8'h03;
      4'd3, 4'd4:       b = 8'h02;
      4'd5:             b = 8'h08;
      4'd6:             b = 8'h0F;
      4'd7:             b = 8'h01;
      4'd8:             b = 8'h06;
      default:          b = 8'h00;
    endcase
    return b;
  endfunction

  // Extra wait after each start-up command, in microseconds
  function automatic logic [13:0] init_wait_us(input logic [3:0] idx);
    logic [13:0] w;
    unique case (idx)
      4'd0, 4'd2, 4'd8:             w = 14'd10000;
      4'd1:                         w = 14'd200;
      4'd3, 4'd4, 4'd5, 4'd6, 4'd7: w = 14'd100;
      default:                      w = 14'd0;
    endcase
    return w;
  endfunction

endpackage

### hdl/char_lcd_nibble_write_sequencer.sv
// ---------------------------------------------------------------------------
// char_lcd_nibble_write_sequencer
// Drives a character LCD over a 4-bit bus. Timer-tick beats advance the
// E pulse sequence; write and init beats start a byte or the start-up list.
// ---------------------------------------------------------------------------
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+-------------------------
//  in_     | in        | in_valid / in_ready       | in_beat_t (op, rs, byte)
//  out_    | out       | out_valid / out_ready     | out_beat_t (pins, flags)
//  cfg     | in        | APB psel/penable, pready=1 | ticks_per_us at 0x0
//
//  The phase, countdown and one segment-length multiply sit combinationally
//  between the accepted beat and the result register.
//  A new beat is taken each cycle while the result register is empty or
//  being drained; out_ready low holds the result and stalls the input.
//  rst_n is synchronous and active low; no clearing pass is needed.
// ---------------------------------------------------------------------------
module char_lcd_nibble_write_sequencer #(
  parameter int PULSE_US    = clns_pkg::PULSE_US_DEF,
  parameter int BYTE_GAP_US = clns_pkg::BYTE_GAP_US_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  clns_pkg::in_beat_t         in_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output clns_pkg::out_beat_t        out_data,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [clns_pkg::CFG_AW-1:0] paddr,
  input  logic [clns_pkg::CFG_DW-1:0] pwdata,
  output logic [clns_pkg::CFG_DW-1:0] prdata,
  output logic                       pready
);
  import clns_pkg::*;

  // Widths of the microsecond value and the tick product
  localparam int GAP_MAX = BYTE_GAP_US + INIT_WAIT_MAX;
  localparam int US_MAX  = (GAP_MAX > PULSE_US) ? GAP_MAX : PULSE_US;
  localparam int US_W    = $clog2(US_MAX + 1);
  localparam int PROD_W  = (US_W + TPU_W > CNT_W) ? US_W + TPU_W : CNT_W + 1;

  // Sequencer state
  phase_t             phase_r, phase_nxt;
  logic [CNT_W-1:0]   wait_r, wait_nxt;
  logic [7:0]         byte_r, byte_nxt;
  logic               rs_r, rs_nxt;
  logic [IDX_W-1:0]   idx_r, idx_nxt;
  logic               init_r, init_nxt;
  logic               en_r, en_nxt;
  logic [3:0]         nib_r, nib_nxt;
  logic               rej;

  logic [TPU_W-1:0]   tpu_r;
  logic               out_valid_r;
  out_beat_t          out_r, out_nxt;

  logic               in_fire;
  logic               busy;
  logic [IDX_W-1:0]   idx_inc;
  logic [US_W-1:0]    us_sel;
  logic [PROD_W-1:0]  prod;
  logic [CNT_W-1:0]   ticks;

  // Handshake
  assign in_fire   = in_valid && in_ready;
  assign in_ready  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign busy      = (phase_r != PH_IDLE);
  assign idx_inc   = idx_r + IDX_W'(1);

  // Configuration port
  assign pready = 1'b1;
  always_comb begin
    prdata = '0;
    if (paddr[CFG_AW-1:2] == REG_TPU) begin
      prdata = CFG_DW'(tpu_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tpu_r <= TPU_RESET;
    end else if (psel && penable && pwrite && pready
                 && paddr[CFG_AW-1:2] == REG_TPU) begin
      tpu_r <= pwdata[TPU_W-1:0];
    end
  end

  // Segment length: the gap after the low nibble, a pulse segment otherwise
  always_comb begin
    us_sel = US_W'(PULSE_US);
    if (phase_r == PH_LO_HOLD) begin
      us_sel = US_W'(BYTE_GAP_US);
      if (init_r && idx_r < INIT_LEN) begin
        us_sel = US_W'(BYTE_GAP_US) + US_W'(init_wait_us(idx_r));
      end
    end
  end

  assign prod  = PROD_W'(us_sel) * PROD_W'(tpu_r);
  assign ticks = (prod > PROD_W'(COUNT_MAX)) ? COUNT_MAX : prod[CNT_W-1:0];

  // Next state
  always_comb begin
    phase_nxt = phase_r;
    wait_nxt  = wait_r;
    byte_nxt  = byte_r;
    rs_nxt    = rs_r;
    idx_nxt   = idx_r;
    init_nxt  = init_r;
    en_nxt    = en_r;
    nib_nxt   = nib_r;
    rej       = 1'b0;
    unique case (op_t'(in_data.op))
      OP_TICK: begin
        if (busy) begin
          if (wait_r <= CNT_W'(1)) begin
            unique case (phase_r)
              PH_HI_SETUP, PH_LO_SETUP: begin
                en_nxt    = 1'b1;
                phase_nxt = (phase_r == PH_HI_SETUP) ? PH_HI_PULSE : PH_LO_PULSE;
                wait_nxt  = ticks;
              end
              PH_HI_PULSE, PH_LO_PULSE: begin
                en_nxt    = 1'b0;
                phase_nxt = (phase_r == PH_HI_PULSE) ? PH_HI_HOLD : PH_LO_HOLD;
                wait_nxt  = ticks;
              end
              PH_HI_HOLD: begin
                nib_nxt   = byte_r[3:0];
                en_nxt    = 1'b0;
                phase_nxt = PH_LO_SETUP;
                wait_nxt  = ticks;
              end
              PH_LO_HOLD: begin
                en_nxt    = 1'b0;
                phase_nxt = PH_GAP;
                wait_nxt  = ticks;
              end
              PH_GAP, PH_IDLE: begin
                // end of a byte: next start-up command or back to idle
                if (init_r && idx_inc < INIT_LEN) begin
                  idx_nxt   = idx_inc;
                  byte_nxt  = init_byte(idx_inc);
                  rs_nxt    = 1'b0;
                  nib_nxt   = byte_nxt[7:4];
                  en_nxt    = 1'b0;
                  phase_nxt = PH_HI_SETUP;
                  wait_nxt  = ticks;
                end else begin
                  if (init_r) begin
                    idx_nxt  = idx_inc;
                    init_nxt = 1'b0;
                  end
                  phase_nxt = PH_IDLE;
                  wait_nxt  = '0;
                  en_nxt    = 1'b0;
                end
              end
            endcase
          end else begin
            wait_nxt = wait_r - CNT_W'(1);
          end
        end
      end
      OP_WRITE, OP_INIT: begin
        if (busy) begin
          rej = 1'b1;
        end else begin
          idx_nxt   = '0;
          init_nxt  = (in_data.op == OP_INIT);
          byte_nxt  = (in_data.op == OP_INIT) ? init_byte('0) : in_data.byte_value;
          rs_nxt    = (in_data.op == OP_INIT) ? 1'b0 : in_data.reg_select;
          nib_nxt   = byte_nxt[7:4];
          en_nxt    = 1'b0;
          phase_nxt = PH_HI_SETUP;
          wait_nxt  = ticks;
        end
      end
      OP_NONE: begin
        // reserved code: no effect
      end
    endcase
  end

  // Result beat from the updated state
  always_comb begin
    out_nxt.enable_pin = en_nxt;
    out_nxt.rs_pin     = rs_nxt;
    out_nxt.data_pins  = nib_nxt;
    out_nxt.busy_res   = (phase_nxt != PH_IDLE);
    out_nxt.rejected   = rej;
  end

  // State and result registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      wait_r      <= '0;
      byte_r      <= '0;
      rs_r        <= 1'b0;
      idx_r       <= '0;
      init_r      <= 1'b0;
      en_r        <= 1'b0;
      nib_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        phase_r     <= phase_nxt;
        wait_r      <= wait_nxt;
        byte_r      <= byte_nxt;
        rs_r        <= rs_nxt;
        idx_r       <= idx_nxt;
        init_r      <= init_nxt;
        en_r        <= en_nxt;
        nib_r       <= nib_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_r <= out_nxt;
    end
  end

endmodule

### hdl/clns_checker.sv
// ---------------------------------------------------------------------------
// clns_checker
// Port-level checks on the LCD nibble write sequencer, bound to the top.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module clns_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input clns_pkg::out_beat_t out_data
);
  import clns_pkg::*;

  // A dropped request never comes from an idle sequencer
  `ASSERT_IMP(a_rej_busy, out_valid && out_data.rejected, out_data.busy_res, "reject while idle")

  // E is low whenever the sequencer is idle
  `ASSERT_IMP(a_idle_e_low, out_valid && !out_data.busy_res, !out_data.enable_pin, "E high at idle")

  // Input is taken whenever the result register is empty
  `ASSERT_IMP(a_ready_empty, !out_valid, in_ready, "stalled with empty output")

  // A stalled result beat holds
  `ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "result beat changed")

endmodule

bind char_lcd_nibble_write_sequencer clns_checker u_clns_checker (.*);

### dv/char_lcd_nibble_write_sequencer_checker.sv
// ----------------------------------------------------------------------------
// char_lcd_nibble_write_sequencer_checker
// Watches the beat, result and APB ports of the LCD sequencer. It keeps its
// own copy of the rate register and of the E-pulse sequence, forecasts the
// pin state for every accepted input beat and compares each result beat,
// field by field, against the oldest forecast still waiting.
// ----------------------------------------------------------------------------
module char_lcd_nibble_write_sequencer_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  clns_pkg::in_beat_t            in_data,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  clns_pkg::out_beat_t           out_data,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [clns_pkg::CFG_AW-1:0]   paddr,
  input  logic [clns_pkg::CFG_DW-1:0]   pwdata,
  input  logic                          pready,
  output int                            mismatches,
  output int                            beats_due
);
  import clns_pkg::*;

  localparam logic [CFG_AW-1:0] TPU_ADDR = {REG_TPU, 2'b00};

  // Start-up command list and the extra wait after each command (us)
  localparam logic [0:8][7:0]  BOOT_CMD  = {8'h03, 8'h03, 8'h03, 8'h02, 8'h02,
                                            8'h08, 8'h0F, 8'h01, 8'h06};
  localparam logic [0:8][13:0] BOOT_WAIT = {14'd10000, 14'd200, 14'd10000,
                                            14'd100, 14'd100, 14'd100,
                                            14'd100, 14'd100, 14'd10000};

  // Shadow of the sequencer
  logic [TPU_W-1:0] rate;
  phase_t           ph;
  logic [CNT_W-1:0] seg_left;
  logic [7:0]       held_byte;
  logic             held_rs;
  logic [IDX_W-1:0] boot_idx;
  logic             boot_on;
  logic             e_lvl;
  logic [3:0]       nibble;

  out_beat_t pin_states_due[$];

  // Segment length in ticks, saturating at the counter width
  function automatic logic [CNT_W-1:0] seg_ticks(input int unsigned us,
                                                 input logic [TPU_W-1:0] tpu);
    longint unsigned t;
    t = us;
    t = t * tpu;
    if (t > COUNT_MAX) t = COUNT_MAX;
    return t[CNT_W-1:0];
  endfunction

  task automatic clear_lcd();
    rate      = TPU_RESET;
    ph        = PH_IDLE;
    seg_left  = '0;
    held_byte = '0;
    held_rs   = 1'b0;
    boot_idx  = '0;
    boot_on   = 1'b0;
    e_lvl     = 1'b0;
    nibble    = '0;
  endtask

  // Latch a byte and start on its high nibble
  task automatic load_byte(input logic [7:0] b, input logic rs);
    held_byte = b;
    held_rs   = rs;
    nibble    = b[7:4];
    e_lvl     = 1'b0;
    ph        = PH_HI_SETUP;
    seg_left  = seg_ticks(PULSE_US_DEF, rate);
  endtask

  // End of a segment: move to the next one
  task automatic advance_lcd();
    int unsigned us;
    logic        go_idle;
    go_idle = 1'b0;
    case (ph)
      PH_HI_SETUP, PH_LO_SETUP: begin
        e_lvl    = 1'b1;
        ph       = phase_t'(ph + 3'd1);
        seg_left = seg_ticks(PULSE_US_DEF, rate);
      end
      PH_HI_PULSE, PH_LO_PULSE: begin
        e_lvl    = 1'b0;
        ph       = phase_t'(ph + 3'd1);
        seg_left = seg_ticks(PULSE_US_DEF, rate);
      end
      PH_HI_HOLD: begin
        nibble   = held_byte[3:0];
        e_lvl    = 1'b0;
        ph       = PH_LO_SETUP;
        seg_left = seg_ticks(PULSE_US_DEF, rate);
      end
      PH_LO_HOLD: begin
        // byte gap, stretched by the start-up wait of the current command
        us = BYTE_GAP_US_DEF;
        if (boot_on && boot_idx < INIT_LEN) us = us + BOOT_WAIT[boot_idx];
        e_lvl    = 1'b0;
        ph       = PH_GAP;
        seg_left = seg_ticks(us, rate);
      end
      default: begin
        go_idle = 1'b1;
        if (boot_on) begin
          boot_idx = boot_idx + 4'd1;
          if (boot_idx < INIT_LEN) begin
            load_byte(BOOT_CMD[boot_idx], 1'b0);
            go_idle = 1'b0;
          end else begin
            boot_on = 1'b0;
          end
        end
        if (go_idle) begin
          ph       = PH_IDLE;
          seg_left = '0;
          e_lvl    = 1'b0;
        end
      end
    endcase
  endtask

  // Apply one input beat and return the pin state that follows it
  task automatic predict_pins(input in_beat_t beat, output out_beat_t pins);
    logic busy;
    logic rej;
    busy = (ph != PH_IDLE);
    rej  = 1'b0;
    case (op_t'(beat.op))
      OP_TICK: begin
        if (busy) begin
          if (seg_left <= 1) advance_lcd();
          else seg_left = seg_left - 1'b1;
        end
      end
      OP_WRITE: begin
        if (busy) begin
          rej = 1'b1;
        end else begin
          boot_on  = 1'b0;
          boot_idx = '0;
          load_byte(beat.byte_value, beat.reg_select);
        end
      end
      OP_INIT: begin
        if (busy) begin
          rej = 1'b1;
        end else begin
          boot_on  = 1'b1;
          boot_idx = '0;
          load_byte(BOOT_CMD[0], 1'b0);
        end
      end
      default: ;
    endcase
    pins.enable_pin = e_lvl;
    pins.rs_pin     = held_rs;
    pins.data_pins  = nibble;
    pins.busy_res   = busy || (ph != PH_IDLE) ? (ph != PH_IDLE) : 1'b0;
    pins.rejected   = rej;
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  // Result beats are popped before the same edge's input beat is pushed:
  // the result register is loaded on the edge that accepts the input beat.
  always @(posedge clk) begin
    out_beat_t want;
    out_beat_t fresh;
    if (!rst_n) begin
      clear_lcd();
      pin_states_due.delete();
      mismatches = 0;
      beats_due  = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (pin_states_due.size() == 0) begin
          $error("result beat with no forecast waiting");
          mismatches++;
        end else begin
          want = pin_states_due.pop_front();
          check_field("enable_pin", want.enable_pin, out_data.enable_pin);
          check_field("rs_pin",     want.rs_pin,     out_data.rs_pin);
          check_field("data_pins",  want.data_pins,  out_data.data_pins);
          check_field("busy_res",   want.busy_res,   out_data.busy_res);
          check_field("rejected",   want.rejected,   out_data.rejected);
        end
      end
      if (psel && penable && pwrite && pready && paddr == TPU_ADDR)
        rate = pwdata[TPU_W-1:0];
      if (in_valid && in_ready) begin
        predict_pins(in_data, fresh);
        pin_states_due.push_back(fresh);
      end
      beats_due = pin_states_due.size();
    end
  end

endmodule

### dv/char_lcd_nibble_write_sequencer_test.sv
// ----------------------------------------------------------------------------
// char_lcd_nibble_write_sequencer_test
// Stimulus and verdict for the LCD nibble sequencer. Directed beats cover
// idle ticks, ignored opcodes, busy rejection and a full start-up list;
// random write/init sequences with tick trains then run at zero and unit
// timer rates, with random stalls on both channels and one long result hold-off.
// ----------------------------------------------------------------------------
module char_lcd_nibble_write_sequencer_test;
  import clns_pkg::*;

  localparam logic [CFG_AW-1:0] TPU_ADDR = {REG_TPU, 2'b00};

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  in_beat_t            in_data;
  logic                out_valid;
  logic                out_ready;
  out_beat_t           out_data;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [CFG_AW-1:0]   paddr;
  logic [CFG_DW-1:0]   pwdata;
  logic [CFG_DW-1:0]   prdata;
  logic                pready;
  int                  mismatches;
  int                  beats_due;

  bit                  calm;
  bit                  long_hold;
  logic [TPU_W-1:0]    cur_tpu;

  char_lcd_nibble_write_sequencer DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  char_lcd_nibble_write_sequencer_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .pready     (pready),
    .mismatches (mismatches),
    .beats_due  (beats_due)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Run limit
  initial begin
    #2000000;
    $display("Regression FAIL");
    $finish;
  end

  // Result side: random stalls, one long hold-off on request
  initial begin
    out_ready = 1'b0;
    wait (rst_n);
    forever begin
      @(negedge clk);
      if (long_hold) begin
        out_ready <= 1'b0;
        repeat (300) @(negedge clk);
        long_hold = 1'b0;
        out_ready <= 1'b1;
      end else if (!calm && $urandom_range(0, 99) < 10) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(negedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Offer one beat, after an optional idle burst, and wait for acceptance
  task automatic send_beat(input op_t op, input logic rs, input logic [7:0] value);
    in_beat_t beat;
    beat.op         = op;
    beat.reg_select = rs;
    beat.byte_value = value;
    @(negedge clk);
    if (!calm && $urandom_range(0, 99) < 12) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= beat;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Timer ticks; the unused fields carry noise
  task automatic send_ticks(input int n);
    logic [31:0] r;
    repeat (n) begin
      r = $urandom;
      send_beat(OP_TICK, r[8], r[7:0]);
    end
  endtask

  // Drop valid and wait for every forecast to be met
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (beats_due != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  task automatic write_tpu(input logic [TPU_W-1:0] value);
    settle();
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= TPU_ADDR;
    pwdata  <= CFG_DW'(value);
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    cur_tpu = value;
  endtask

  // Ticks that one byte takes from its request to idle at a given rate
  function automatic int byte_ticks(input logic [TPU_W-1:0] t);
    int seg;
    int gap;
    seg = (t == 0) ? 1 : PULSE_US_DEF * t;
    gap = (t == 0) ? 1 : BYTE_GAP_US_DEF * t;
    return 6 * seg + gap;
  endfunction

  // Mostly complete request-plus-ticks sequences, with noise around them
  task automatic run_random(input int budget, input bit allow_init);
    int          sent;
    int          len;
    logic [31:0] r;
    op_t         op;
    sent = 0;
    while (sent < budget) begin
      r = $urandom;
      if ($urandom_range(0, 99) < 75) begin
        if (allow_init && $urandom_range(0, 99) < 20) begin
          send_beat(OP_INIT, r[8], r[7:0]);
          len = 9 * byte_ticks(cur_tpu);
        end else begin
          send_beat(OP_WRITE, r[8], r[7:0]);
          len = byte_ticks(cur_tpu);
        end
        // now and then cut short, so the next request lands while busy
        len = len + $urandom_range(0, 2);
        if ($urandom_range(0, 9) == 0) len = len - $urandom_range(1, 3);
        repeat (len) begin
          if ($urandom_range(0, 99) < 3) begin
            r = $urandom;
            send_beat(op_t'($urandom_range(1, 3)), r[8], r[7:0]);
          end
          send_ticks(1);
        end
        sent = sent + len + 1;
      end else begin
        op = op_t'($urandom_range(0, 3));
        send_beat(op, r[8], r[7:0]);
        if (op != OP_NONE) sent++;
      end
    end
  endtask

  // Main sequence
  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    psel      = 1'b0;
    penable   = 1'b0;
    pwrite    = 1'b0;
    paddr     = '0;
    pwdata    = '0;
    calm      = 1'b0;
    long_hold = 1'b0;
    cur_tpu   = TPU_RESET;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    // Reset rate: idle tick, ignored op, then requests while busy
    send_beat(OP_TICK,  1'b1, 8'hFF);
    send_beat(OP_NONE,  1'b1, 8'hFF);
    send_beat(OP_WRITE, 1'b1, 8'hFF);
    send_beat(OP_WRITE, 1'b0, 8'h00);
    send_beat(OP_INIT,  1'b1, 8'hAA);
    send_beat(OP_NONE,  1'b0, 8'h55);
    send_ticks(3);

    // Zero rate taken mid-byte: the current segment runs out, later ones are one tick each
    write_tpu(8'd0);
    send_ticks(40);
    send_beat(OP_WRITE, 1'b0, 8'h00);
    send_ticks(byte_ticks(cur_tpu));
    send_beat(OP_WRITE, 1'b1, 8'h5A);
    send_ticks(3);
    send_beat(OP_NONE,  1'b1, 8'h0F);
    send_beat(OP_INIT,  1'b0, 8'hF0);
    send_ticks(byte_ticks(cur_tpu) - 3);
    send_beat(OP_INIT,  1'b0, 8'h00);
    send_ticks(9 * byte_ticks(cur_tpu) + 1);
    send_beat(OP_NONE,  1'b0, 8'h00);

    // Random at zero rate, starting under a long result hold-off
    long_hold = 1'b1;
    run_random(180, 1'b1);

    // Lowest nonzero rate
    write_tpu(8'd1);
    run_random(200, 1'b0);

    // Back to zero rate, no idling from here on
    write_tpu(8'd0);
    calm = 1'b1;
    run_random(150, 1'b1);
    send_ticks(9 * byte_ticks(cur_tpu) + 5);

    // Top rate: one byte started, ticked a little, requests bounced
    write_tpu(8'd255);
    send_beat(OP_WRITE, 1'b1, 8'hC3);
    send_ticks(30);
    send_beat(OP_WRITE, 1'b0, 8'h3C);
    send_beat(OP_INIT,  1'b1, 8'h81);
    send_beat(OP_NONE,  1'b1, 8'hFF);
    send_ticks(5);

    settle();
    repeat (16) @(negedge clk);
    if (mismatches == 0 && beats_due == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+hdl
hdl/clns_pkg.sv
hdl/char_lcd_nibble_write_sequencer.sv
hdl/clns_checker.sv
dv/char_lcd_nibble_write_sequencer_checker.sv
dv/char_lcd_nibble_write_sequencer_test.sv
